// ===== rtl/ddgr_pkg.sv =====
// shared types, constants and glyph font of the decimal digit glyph renderer
package ddgr_pkg;

    localparam int MAX_DIGITS    = 8;
    localparam int GLYPH_ROWS    = 5;
    localparam int GLYPH_COLUMNS = 7;
    localparam int VALUE_W       = 27;
    localparam int DIGIT_W       = 4;
    localparam int ROW_W         = 3;
    localparam int POS_W         = 3;
    localparam int LEN_W         = 4;
    localparam int BIT_CNT_W     = 5;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 27'd99999999;

    // per-cell control from the sequencer
    typedef struct packed {
        logic clear;
        logic dabble;
        logic rotate;
    } cell_ctrl_t;

    // glyph rows, msb is the leftmost column
    localparam logic [GLYPH_COLUMNS-1:0] FONT [10][GLYPH_ROWS] = '{
        '{7'h1C, 7'h22, 7'h22, 7'h22, 7'h1C},
        '{7'h06, 7'h36, 7'h06, 7'h06, 7'h06},
        '{7'h1C, 7'h22, 7'h04, 7'h18, 7'h3E},
        '{7'h3C, 7'h02, 7'h1C, 7'h02, 7'h3C},
        '{7'h22, 7'h22, 7'h3E, 7'h02, 7'h02},
        '{7'h3E, 7'h20, 7'h3C, 7'h02, 7'h3C},
        '{7'h1C, 7'h20, 7'h3C, 7'h22, 7'h1C},
        '{7'h3E, 7'h04, 7'h08, 7'h10, 7'h20},
        '{7'h1C, 7'h22, 7'h1C, 7'h22, 7'h1C},
        '{7'h1C, 7'h22, 7'h1E, 7'h02, 7'h1C}
    };

    // column mask of one glyph row, blank for codes that are no digit
    function automatic logic [GLYPH_COLUMNS-1:0] glyph_bits(
        input logic [DIGIT_W-1:0] digit,
        input logic [ROW_W-1:0]   row
    );
        logic [GLYPH_COLUMNS-1:0] bits;
        bits = '0;
        if (digit <= 4'd9 && row <= 3'd4) begin
            bits = FONT[digit][row];
        end
        return bits;
    endfunction

endpackage

// ===== rtl/ddgr_cell.sv =====
// one decimal digit cell: shift-add-3 step during conversion, rotation during scan
module ddgr_cell (
    input  logic                        clk,
    input  ddgr_pkg::cell_ctrl_t        ctrl,
    input  logic                        bit_in,
    output logic                        bit_out,
    input  logic [ddgr_pkg::DIGIT_W-1:0] digit_in,
    output logic [ddgr_pkg::DIGIT_W-1:0] digit
);

    logic [ddgr_pkg::DIGIT_W-1:0] digit_reg;
    logic [ddgr_pkg::DIGIT_W-1:0] digit_next;
    logic [ddgr_pkg::DIGIT_W-1:0] adj;

    // add 3 when the digit would overflow on doubling
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    assign bit_out = adj[ddgr_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

    // next digit by operation
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {adj[ddgr_pkg::DIGIT_W-2:0], bit_in};
        end else if (ctrl.rotate) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== rtl/decimal_digit_glyph_renderer_core.sv =====
// top level of the decimal digit glyph renderer: sequencer, digit cell chain, output register
//
// Takes one unsigned value per item and emits one item per glyph row of each
// significant decimal digit, rows top first and digits left to right within a
// row; tlast marks the final item of a value. A value above 99999999 gives a
// single item with tuser set and all tdata fields zero; zero gives no items.
// One value is handled at a time: the binary value is shifted one bit per
// cycle through a chain of eight digit cells, a sizing state then counts the
// significant digits, then the digits rotate through the chain for five rows
// of eight steps each; a step that emits waits while the output is stalled.
// An out-of-range value is answered from the idle state without conversion.
module decimal_digit_glyph_renderer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [26:0] value, [31:27] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] glyph_row, [5:3] digit_position,
                                   // [9:6] digit_value, [16:10] row_mask, [23:17] zero
    output logic        m_tlast,   // last_of_run
    output logic [0:0]  m_tuser    // [0] too_large
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_SCAN
    } state_t;

    localparam int ND = ddgr_pkg::MAX_DIGITS;

    state_t                              state_reg, state_next;
    logic [ddgr_pkg::VALUE_W-1:0]        value_reg, value_next;
    logic [ddgr_pkg::BIT_CNT_W-1:0]      bcnt_reg, bcnt_next;
    logic [ddgr_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [ddgr_pkg::ROW_W-1:0]          row_reg, row_next;
    logic [ddgr_pkg::POS_W-1:0]          idx_reg, idx_next;

    logic                                m_tvalid_reg, m_tvalid_next;
    logic [ddgr_pkg::ROW_W-1:0]          o_row_reg, o_row_next;
    logic [ddgr_pkg::POS_W-1:0]          o_pos_reg, o_pos_next;
    logic [ddgr_pkg::DIGIT_W-1:0]        o_dig_reg, o_dig_next;
    logic [ddgr_pkg::GLYPH_COLUMNS-1:0]  o_mask_reg, o_mask_next;
    logic                                o_big_reg, o_big_next;
    logic                                o_last_reg, o_last_next;

    ddgr_pkg::cell_ctrl_t                cell_ctrl;
    logic [ND:0]                         carry;
    logic [ddgr_pkg::DIGIT_W-1:0]        digits [ND];
    logic [ddgr_pkg::LEN_W-1:0]          len_calc;
    logic [ddgr_pkg::VALUE_W-1:0]        in_value;
    logic                                out_free;
    logic                                accept;
    logic                                emit;
    logic                                adv;
    logic [ddgr_pkg::DIGIT_W-1:0]        top_digit;

    assign in_value  = s_tdata[ddgr_pkg::VALUE_W-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign top_digit = digits[ND-1];

    // chain of digit cells, lsd at index 0, rotation moves digits upward
    assign carry[0] = value_reg[ddgr_pkg::VALUE_W-1];

    for (genvar i = 0; i < ND; i++) begin : g_cell
        ddgr_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .bit_in   (carry[i]),
            .bit_out  (carry[i+1]),
            .digit_in (digits[(i + ND - 1) % ND]),
            .digit    (digits[i])
        );
    end

    // count of significant digits
    always_comb
    begin
        len_calc = '0;
        for (int i = 0; i < ND; i++) begin
            if (digits[i] != '0) begin
                len_calc = ddgr_pkg::LEN_W'(i + 1);
            end
        end
    end

    // scan: emit only cells that hold significant digits
    assign emit = ({1'b0, idx_reg} < len_reg);
    assign adv  = !emit || out_free;

    // sequencer and output register
    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        bcnt_next     = bcnt_reg;
        len_next      = len_reg;
        row_next      = row_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        o_row_next    = o_row_reg;
        o_pos_next    = o_pos_reg;
        o_dig_next    = o_dig_reg;
        o_mask_next   = o_mask_reg;
        o_big_next    = o_big_reg;
        o_last_next   = o_last_reg;
        cell_ctrl     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (in_value > ddgr_pkg::VALUE_LIMIT) begin
                        m_tvalid_next = 1'b1;
                        o_row_next    = '0;
                        o_pos_next    = '0;
                        o_dig_next    = '0;
                        o_mask_next   = '0;
                        o_big_next    = 1'b1;
                        o_last_next   = 1'b1;
                    end else begin
                        cell_ctrl.clear = 1'b1;
                        value_next      = in_value;
                        bcnt_next       = ddgr_pkg::BIT_CNT_W'(ddgr_pkg::VALUE_W - 1);
                        state_next      = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                cell_ctrl.dabble = 1'b1;
                value_next       = {value_reg[ddgr_pkg::VALUE_W-2:0], 1'b0};
                bcnt_next        = bcnt_reg - 1'b1;
                if (bcnt_reg == '0) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                len_next = len_calc;
                row_next = '0;
                idx_next = ddgr_pkg::POS_W'(ND - 1);
                state_next = (len_calc == '0) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (adv) begin
                    cell_ctrl.rotate = 1'b1;
                    idx_next         = idx_reg - 1'b1;
                    if (emit) begin
                        m_tvalid_next = 1'b1;
                        o_row_next    = row_reg;
                        o_pos_next    = ddgr_pkg::POS_W'(len_reg - 1'b1 - {1'b0, idx_reg});
                        o_dig_next    = top_digit;
                        o_mask_next   = ddgr_pkg::glyph_bits(top_digit, row_reg);
                        o_big_next    = 1'b0;
                        o_last_next   = (row_reg == ddgr_pkg::ROW_W'(ddgr_pkg::GLYPH_ROWS - 1))
                                        && (idx_reg == '0);
                    end
                    if (idx_reg == '0) begin
                        row_next = row_reg + 1'b1;
                        if (row_reg == ddgr_pkg::ROW_W'(ddgr_pkg::GLYPH_ROWS - 1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload and counters
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        bcnt_reg   <= bcnt_next;
        len_reg    <= len_next;
        row_reg    <= row_next;
        idx_reg    <= idx_next;
        o_row_reg  <= o_row_next;
        o_pos_reg  <= o_pos_next;
        o_dig_reg  <= o_dig_next;
        o_mask_reg <= o_mask_next;
        o_big_reg  <= o_big_next;
        o_last_reg <= o_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, o_mask_reg, o_dig_reg, o_pos_reg, o_row_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_big_reg;

`ifndef SYNTHESIS
    // error item stands alone with blank fields
    a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("error item not blank or not last");

    // digit items carry a real digit and row
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[9:6] <= 4'd9) && (m_tdata[2:0] <= 3'd4))
        else $error("digit item out of range");

    // the final digit item belongs to the bottom row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser[0] |-> (m_tdata[2:0] == 3'd4))
        else $error("last item not on bottom row");

    // scanning only with a sized number
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (len_reg != '0) && (len_reg <= 4'd8))
        else $error("scan with bad digit count");
`endif

endmodule

// ===== verif/decimal_digit_glyph_renderer_core_tb.sv =====
// self-checking testbench for the decimal digit glyph renderer core
`timescale 1ns / 1ps

module decimal_digit_glyph_renderer_core_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RANDOM_VALUES = 103;
    localparam int PRINT_CAP     = 60;

    // one expected glyph row item
    typedef struct packed {
        logic [ddgr_pkg::ROW_W-1:0]         glyph_row;
        logic [ddgr_pkg::POS_W-1:0]         digit_position;
        logic [ddgr_pkg::DIGIT_W-1:0]       digit_value;
        logic [ddgr_pkg::GLYPH_COLUMNS-1:0] row_mask;
        logic                               too_large;
        logic                               last_of_run;
    } glyph_item_t;

    // font of the renderer, msb is the leftmost column
    localparam logic [6:0] DIGIT_FONT [10][5] = '{
        '{7'h1C, 7'h22, 7'h22, 7'h22, 7'h1C},
        '{7'h06, 7'h36, 7'h06, 7'h06, 7'h06},
        '{7'h1C, 7'h22, 7'h04, 7'h18, 7'h3E},
        '{7'h3C, 7'h02, 7'h1C, 7'h02, 7'h3C},
        '{7'h22, 7'h22, 7'h3E, 7'h02, 7'h02},
        '{7'h3E, 7'h20, 7'h3C, 7'h02, 7'h3C},
        '{7'h1C, 7'h20, 7'h3C, 7'h22, 7'h1C},
        '{7'h3E, 7'h04, 7'h08, 7'h10, 7'h20},
        '{7'h1C, 7'h22, 7'h1C, 7'h22, 7'h1C},
        '{7'h1C, 7'h22, 7'h1E, 7'h02, 7'h1C}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [26:0] value, [31:27] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [2:0] glyph_row, [5:3] digit_position,
                                  // [9:6] digit_value, [16:10] row_mask, [23:17] zero
    logic        m_tlast;         // last_of_run
    logic [0:0]  m_tuser;         // [0] too_large

    logic [ddgr_pkg::VALUE_W-1:0] values_to_send [$];
    glyph_item_t                  glyph_rows_due [$];
    int                           mismatch_count = 0;
    int                           cycle_count    = 0;
    int                           burst_left     = 0;
    int                           gap_left       = 0;
    int                           ready_mode     = 0;
    int                           ready_phase    = 0;

    decimal_digit_glyph_renderer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // work out the glyph rows that one accepted value causes
    task automatic predict_glyph_rows(input logic [ddgr_pkg::VALUE_W-1:0] value);
        int unsigned rest;
        int          n_digits;
        int          total;
        int          k;
        logic [3:0]  digits [ddgr_pkg::MAX_DIGITS];
        glyph_item_t row_item;
        row_item = '0;
        n_digits = 0;
        k        = 0;
        if (value > ddgr_pkg::VALUE_LIMIT)
        begin
            row_item.too_large   = 1'b1;
            row_item.last_of_run = 1'b1;
            glyph_rows_due.push_back(row_item);
        end
        else
        begin
            rest = value;
            while (rest > 0)
            begin
                rest = rest / 10;
                n_digits++;
            end
            rest = value;
            for (int i = n_digits - 1; i >= 0; i--)
            begin
                digits[i] = 4'(rest % 10);
                rest      = rest / 10;
            end
            total = n_digits * ddgr_pkg::GLYPH_ROWS;
            for (int r = 0; r < ddgr_pkg::GLYPH_ROWS; r++)
            begin
                for (int p = 0; p < n_digits; p++)
                begin
                    row_item.glyph_row      = 3'(r);
                    row_item.digit_position = 3'(p);
                    row_item.digit_value    = digits[p];
                    row_item.row_mask       = DIGIT_FONT[digits[p]][r];
                    row_item.too_large      = 1'b0;
                    row_item.last_of_run    = (k == total - 1);
                    glyph_rows_due.push_back(row_item);
                    k++;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    // value sender: bursts of random length, random gaps in between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_glyph_rows(s_tdata[ddgr_pkg::VALUE_W-1:0]);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (values_to_send.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, values_to_send.pop_front()};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 10);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, a new random mode is picked periodically
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_mode  <= 0;
            ready_phase <= 0;
        end
        else
        begin
            ready_phase <= ready_phase + 1;
            if (ready_phase % 300 == 299)
            begin
                ready_mode <= $urandom_range(0, 3);
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (ready_phase % 7 < 4);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        glyph_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (glyph_rows_due.size() == 0)
            begin
                report_mismatch("unexpected item, tdata", m_tdata, 0);
            end
            else
            begin
                want = glyph_rows_due.pop_front();
                if (m_tdata[2:0] != want.glyph_row)
                    report_mismatch("glyph_row", m_tdata[2:0], want.glyph_row);
                if (m_tdata[5:3] != want.digit_position)
                    report_mismatch("digit_position", m_tdata[5:3], want.digit_position);
                if (m_tdata[9:6] != want.digit_value)
                    report_mismatch("digit_value", m_tdata[9:6], want.digit_value);
                if (m_tdata[16:10] != want.row_mask)
                    report_mismatch("row_mask", m_tdata[16:10], want.row_mask);
                if (m_tuser[0] !== want.too_large)
                    report_mismatch("too_large", m_tuser[0], want.too_large);
                if (m_tlast !== want.last_of_run)
                    report_mismatch("last_of_run", m_tlast, want.last_of_run);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int n_digits;
        int pick;
        // directed values: extremes, every digit, both sides of the limit
        values_to_send.push_back(27'd0);
        values_to_send.push_back(27'd1);
        values_to_send.push_back(27'd9);
        values_to_send.push_back(27'd10);
        values_to_send.push_back(27'd0);
        values_to_send.push_back(27'd12345678);
        values_to_send.push_back(27'd90876543);
        values_to_send.push_back(27'd10000000);
        values_to_send.push_back(27'd99999999);
        values_to_send.push_back(27'd100000000);
        values_to_send.push_back(27'h7FFFFFF);
        values_to_send.push_back(27'd67108864);
        values_to_send.push_back(27'd1010101);
        values_to_send.push_back(27'd5);
        values_to_send.push_back(27'd44);
        values_to_send.push_back(27'd777);
        values_to_send.push_back(27'd99999998);

        // random values, mostly in range with a random digit count
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                n_digits = $urandom_range(1, ddgr_pkg::MAX_DIGITS);
                if (n_digits == 1)
                    values_to_send.push_back(27'($urandom_range(1, 9)));
                else
                    values_to_send.push_back(27'($urandom_range(10 ** (n_digits - 1),
                                                                 10 ** n_digits - 1)));
            end
            else if (pick < 17)
            begin
                values_to_send.push_back(27'($urandom_range(100000000, 134217727)));
            end
            else if (pick < 18)
            begin
                values_to_send.push_back(27'd0);
            end
            else
            begin
                values_to_send.push_back(27'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (values_to_send.size() > 0 || s_tvalid)
            @(posedge clk);
        while (glyph_rows_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && glyph_rows_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== decimal_digit_glyph_renderer_core.f =====
rtl/ddgr_pkg.sv
rtl/ddgr_cell.sv
rtl/decimal_digit_glyph_renderer_core.sv
verif/decimal_digit_glyph_renderer_core_tb.sv
